>>> design/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared constants, types and state encodings for the special pair counter.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COUNT_W  = $clog2(DEPTH + 1);
    localparam int SAMPLE_W = 32;
    localparam int PAIR_W   = 19;
    localparam int LEN_W    = 11;
    localparam int LEN_MAX  = (1 << LEN_W) - 1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_START,
        ST_SCAN,
        ST_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_HEAD,
        SC_RUN
    } scan_state_t;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] n;
    } scan_ctrl_t;

    typedef struct packed {
        logic              done;
        logic [PAIR_W-1:0] pair_count;
    } scan_stat_t;

endpackage

>>> design/spc_sample_if.sv
// ----------------------------------------------------------------------------
// spc_sample_if
// Input channel: one series sample per transaction, with end-of-series mark.
// ----------------------------------------------------------------------------
interface spc_sample_if;
    import spc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;

    modport source (output valid, output sample_value, output last_sample, input ready);
    modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

>>> design/spc_result_if.sv
// ----------------------------------------------------------------------------
// spc_result_if
// Output channel: one result transaction per completed series.
// ----------------------------------------------------------------------------
interface spc_result_if;
    import spc_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAIR_W-1:0] pair_count;
    logic [LEN_W-1:0]  series_length;
    logic              overflowed;

    modport source (output valid, output pair_count, output series_length,
                    output overflowed, input ready);
    modport sink   (input valid, input pair_count, input series_length,
                    input overflowed, output ready);
endinterface

>>> design/spc_ram.sv
// ----------------------------------------------------------------------------
// spc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

>>> design/spc_scan.sv
// ----------------------------------------------------------------------------
// spc_scan
// Pair scan sequencer: streams the stored series out of the sample RAM once
// per left index and counts the special pairs, saturating at full width.
// ----------------------------------------------------------------------------
module spc_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spc_pkg::scan_ctrl_t            ctrl,
    output spc_pkg::scan_stat_t            stat,
    output logic                           rd_en,
    output logic [spc_pkg::ADDR_W-1:0]     rd_addr,
    input  logic [spc_pkg::SAMPLE_W-1:0]   rd_data
);
    import spc_pkg::*;

    scan_state_t                state_reg, state_next;
    logic [ADDR_W-1:0]          i_reg, i_next;
    logic [ADDR_W-1:0]          j_reg, j_next;
    logic [ADDR_W-1:0]          last_idx_reg, last_idx_next;
    logic                       issue_reg, issue_next;
    logic                       valid_reg, valid_next;
    logic                       first_reg, first_next;
    logic                       done_reg, done_next;
    logic [PAIR_W-1:0]          count_reg, count_next;
    logic signed [SAMPLE_W-1:0] ai_reg, ai_next;
    logic signed [SAMPLE_W-1:0] high_reg, high_next;
    logic signed [SAMPLE_W-1:0] low_reg, low_next;

    logic signed [SAMPLE_W-1:0] v;
    logic signed [SAMPLE_W-1:0] low_cand;
    logic                       hit;

    assign v        = $signed(rd_data);
    // running minimum of A[i+1..j], seeded by the first sample after i
    assign low_cand = (first_reg || (v < low_reg)) ? v : low_reg;
    assign hit      = (ai_reg < low_cand) && (v > high_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            issue_reg <= 1'b0;
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        last_idx_reg <= last_idx_next;
        first_reg    <= first_next;
        ai_reg       <= ai_next;
        high_reg     <= high_next;
        low_reg      <= low_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        last_idx_next = last_idx_reg;
        issue_next    = 1'b0;
        valid_next    = 1'b0;
        first_next    = first_reg;
        done_next     = 1'b0;
        count_next    = count_reg;
        ai_next       = ai_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;

        unique case (state_reg)
            SC_IDLE:
            begin
                if (ctrl.start)
                begin
                    count_next    = '0;
                    last_idx_next = ADDR_W'(ctrl.n - COUNT_W'(1));
                    i_next        = '0;
                    if (ctrl.n < COUNT_W'(2))
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = SC_HEAD;
                    end
                end
            end

            SC_HEAD:
            begin
                ai_next    = v;
                high_next  = v;
                first_next = 1'b1;
                j_next     = i_reg + ADDR_W'(1);
                issue_next = 1'b1;
                state_next = SC_RUN;
            end

            SC_RUN:
            begin
                if (issue_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = j_reg;
                    j_next  = j_reg + ADDR_W'(1);
                    issue_next = (j_reg != last_idx_reg);
                end
                valid_next = issue_reg;

                if (valid_reg)
                begin
                    low_next   = low_cand;
                    first_next = 1'b0;
                    if (v > high_reg)
                    begin
                        high_next = v;
                    end
                    if (hit && (count_reg != '1))
                    begin
                        count_next = count_reg + PAIR_W'(1);
                    end
                    // last right index for this i: move on or finish
                    if (!issue_reg)
                    begin
                        if (i_reg == last_idx_reg - ADDR_W'(1))
                        begin
                            done_next  = 1'b1;
                            state_next = SC_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + ADDR_W'(1);
                            rd_en      = 1'b1;
                            rd_addr    = i_reg + ADDR_W'(1);
                            state_next = SC_HEAD;
                        end
                    end
                end
            end

            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    assign stat.done       = done_reg;
    assign stat.pair_count = count_reg;

    a_valid_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (state_reg == SC_RUN))
        else $error("scan data returned outside the run phase");

    a_addr_in_series: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && (state_reg == SC_RUN)) |-> (rd_addr <= last_idx_reg))
        else $error("scan read beyond the stored series");

    a_tail_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == SC_RUN) && !issue_reg) |-> valid_reg)
        else $error("run phase stalled with no read in flight");

endmodule

>>> design/special_pair_counter.sv
// ----------------------------------------------------------------------------
// special_pair_counter
// Loads a series of signed Q16.16 samples and counts its special pairs.
// ----------------------------------------------------------------------------
// Samples arrive one transaction per cycle and are written into a DEPTH-entry
// sample RAM; samples beyond DEPTH are dropped and flagged. The transaction
// marked last_sample closes the series: the input then stalls while the scan
// sequencer reads the series back through the RAM's single read port, one
// sample per cycle, once for every left index i. Once the scan is done, one
// result transaction carries the pair count (saturated at 19 bits), the stored
// length and the overflow flag. The result sits in an output register, so
// loading of the next series resumes while it waits to be taken. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module special_pair_counter (
    input  logic  clk,
    input  logic  rst_n,
    spc_sample_if.sink   samples,
    spc_result_if.source results
);
    import spc_pkg::*;

    top_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               drop_reg, drop_next;
    logic               out_valid_reg, out_valid_next;
    logic [PAIR_W-1:0]  out_pair_reg, out_pair_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_ovf_reg, out_ovf_next;

    logic                 accept;
    logic                 wr_en;
    logic [ADDR_W-1:0]    scan_rd_addr;
    logic                 scan_rd_en;
    logic [SAMPLE_W-1:0]  rd_data;
    scan_ctrl_t           scan_ctrl;
    scan_stat_t           scan_stat;
    logic [LEN_W-1:0]     len_sat;

    assign samples.ready = (state_reg == ST_LOAD);
    assign accept        = samples.valid && samples.ready;
    // store while there is room; a full store drops the sample
    assign wr_en         = accept && (count_reg < COUNT_W'(DEPTH));

    spc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (samples.sample_value),
        .rd_en   (scan_rd_en),
        .rd_addr (scan_rd_addr),
        .rd_data (rd_data)
    );

    assign scan_ctrl.start = (state_reg == ST_START);
    assign scan_ctrl.n     = count_reg;

    spc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (scan_ctrl),
        .stat    (scan_stat),
        .rd_en   (scan_rd_en),
        .rd_addr (scan_rd_addr),
        .rd_data (rd_data)
    );

    // clamp the length to the output field
    assign len_sat = (32'(count_reg) > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pair_reg <= out_pair_next;
        out_len_reg  <= out_len_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        out_pair_next  = out_pair_reg;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg;

        // drop the result once the sink takes it
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (samples.last_sample)
                    begin
                        state_next = ST_START;
                    end
                end
            end

            ST_START:
            begin
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pair_next  = scan_stat.pair_count;
                    out_len_next   = len_sat;
                    out_ovf_next   = drop_reg;
                    count_next     = '0;
                    drop_next      = 1'b0;
                    state_next     = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign results.valid         = out_valid_reg;
    assign results.pair_count    = out_pair_reg;
    assign results.series_length = out_len_reg;
    assign results.overflowed    = out_ovf_reg;

    a_done_while_scanning: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.done |-> (state_reg == ST_SCAN))
        else $error("scan completion outside the scan phase");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("stored count exceeds store depth");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (state_next == ST_LOAD)) |=>
            ((count_reg == '0) && !drop_reg && out_valid_reg))
        else $error("result hand-off did not clear the series state");

endmodule

>>> dv/tb_special_pair_counter.sv
// ----------------------------------------------------------------------------
// tb_special_pair_counter
// Self-checking testbench for the special pair counter.
// ----------------------------------------------------------------------------
// Feeds series of signed Q16.16 samples over the sample channel. The series
// are directed corner cases, a few hundred random samples in short series,
// and one series that overruns the sample store. A scoreboard rebuilds every
// stored series and predicts the pair count, length and overflow flag of
// each one. It checks each result transaction against the oldest prediction.
// Both channels idle at random. One long receiver hold-off backs the block up
// until it stalls its input.
// ----------------------------------------------------------------------------
module tb_special_pair_counter;
    import spc_pkg::*;

    localparam int    CYCLE_LIMIT    = 4_000_000;
    localparam int    RANDOM_ITEMS   = 650;
    localparam int    TAIL_CYCLES    = 64;
    localparam int    HOLD_CYCLES    = 3000;
    localparam int    HOLD_AT_RESULT = 25;
    localparam int    OVERRUN_EXTRA  = 3;
    localparam int    IDLE_PERCENT   = 30;
    localparam longint PAIR_MAX      = (64'd1 << PAIR_W) - 1;

    // Shapes of random series: noise, small values with many ties, rising or
    // falling runs with ties and reversals, and values near the range limits and zero.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_TIES,
        SHAPE_RISING,
        SHAPE_FALLING,
        SHAPE_LIMITS
    } series_shape_t;

    typedef struct {
        logic [PAIR_W-1:0] pairs;
        logic [LEN_W-1:0]  length;
        logic              dropped;
    } series_summary_t;

    // ------------------------------------------------------------------------
    // Scoreboard: collects the series being loaded and, on the marked
    // sample, queues the summary that the block must report for it.
    // ------------------------------------------------------------------------
    class pair_ledger;
        logic signed [SAMPLE_W-1:0] open_series[$];
        logic                       open_dropped;
        series_summary_t            awaited[$];
        int                         errors;

        function new();
            open_dropped = 1'b0;
            errors = 0;
        endfunction

        // A[i] must stay below every later sample up to j, and A[j] must
        // exceed every earlier one from i. Once the running minimum after i
        // falls to A[i], no further j can pair with i.
        function longint count_special_pairs();
            longint                     total;
            int                         n;
            logic signed [SAMPLE_W-1:0] low_after;
            logic signed [SAMPLE_W-1:0] high_before;
            logic signed [SAMPLE_W-1:0] v;
            total = 0;
            n = open_series.size();
            for (int i = 0; i + 1 < n; i++)
            begin
                low_after = open_series[i + 1];
                high_before = open_series[i];
                for (int j = i + 1; j < n; j++)
                begin
                    v = open_series[j];
                    if (v < low_after)
                        low_after = v;
                    if (open_series[i] >= low_after)
                        break;
                    if (v > high_before)
                    begin
                        total++;
                        high_before = v;
                    end
                end
            end
            return total;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] value, logic last);
            series_summary_t s;
            longint          pairs;
            int              len;
            if (open_series.size() < DEPTH)
                open_series.insert(open_series.size(), value);
            else
                open_dropped = 1'b1;
            if (last)
            begin
                pairs = count_special_pairs();
                if (pairs > PAIR_MAX)
                    pairs = PAIR_MAX;
                len = open_series.size();
                if (len > LEN_MAX)
                    len = LEN_MAX;
                s.pairs = PAIR_W'(pairs);
                s.length = LEN_W'(len);
                s.dropped = open_dropped;
                awaited.insert(awaited.size(), s);
                open_series.delete();
                open_dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [PAIR_W-1:0] pairs, logic [LEN_W-1:0] length,
                                   logic dropped);
            series_summary_t s;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result: pair_count %0d series_length %0d overflowed %0b",
                         $time, pairs, length, dropped);
                errors++;
                return;
            end
            s = awaited.pop_front();
            if (pairs !== s.pairs)
            begin
                $display("%0t: pair_count expected %0d, actual %0d", $time, s.pairs, pairs);
                errors++;
            end
            if (length !== s.length)
            begin
                $display("%0t: series_length expected %0d, actual %0d", $time, s.length, length);
                errors++;
            end
            if (dropped !== s.dropped)
            begin
                $display("%0t: overflowed expected %0b, actual %0b", $time, s.dropped, dropped);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    spc_sample_if samples_ch ();
    spc_result_if results_ch ();

    special_pair_counter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch)
    );

    pair_ledger ledger = new();

    int sent_count   = 0;
    int results_seen = 0;
    int cycles       = 0;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Sample side. Drive at the falling edge, take acceptance at the rising
    // edge. Idle at random, except over a window of back-to-back transactions.
    // ------------------------------------------------------------------------
    function automatic bit sender_rests();
        if (sent_count >= 250 && sent_count < 400)
            return 1'b0;
        return ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
        @(negedge clk);
        while (sender_rests())
        begin
            samples_ch.valid <= 1'b0;
            @(negedge clk);
        end
        samples_ch.valid        <= 1'b1;
        samples_ch.sample_value <= value;
        samples_ch.last_sample  <= last;
        // Hold the transaction until the block takes it.
        forever
        begin
            @(posedge clk);
            if (samples_ch.ready)
                break;
        end
        ledger.note_sample(value, last);
        sent_count++;
    endtask

    task automatic send_random_series();
        int                         len;
        int                         pick;
        series_shape_t              shape;
        logic signed [SAMPLE_W-1:0] v;
        pick = $urandom_range(99);
        if (pick < 10)
            len = 1;
        else if (pick < 85)
            len = $urandom_range(12, 2);
        else
            len = $urandom_range(48, 13);
        shape = series_shape_t'($urandom_range(int'(SHAPE_LIMITS), int'(SHAPE_NOISE)));
        v = $urandom();
        for (int k = 0; k < len; k++)
        begin
            case (shape)
                SHAPE_NOISE:
                    v = $urandom();
                SHAPE_TIES:
                begin
                    v = $urandom_range(6);
                    v = v - 3;
                end
                SHAPE_RISING:
                begin
                    if ($urandom_range(9) == 0)
                        v = v - $urandom_range(20);
                    else
                        v = v + $urandom_range(4);
                end
                SHAPE_FALLING:
                begin
                    if ($urandom_range(9) == 0)
                        v = v + $urandom_range(20);
                    else
                        v = v - $urandom_range(4);
                end
                default:
                begin
                    pick = $urandom_range(2);
                    if (pick == 0)
                        v = 32'sh8000_0000 + $urandom_range(2);
                    else if (pick == 1)
                    begin
                        v = $urandom_range(2);
                        v = v - 1;
                    end
                    else
                        v = 32'sh7FFF_FFFF - $urandom_range(2);
                end
            endcase
            push_sample(v, k == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side. Drop ready at random, keep it high over a window of
    // results, and once hold it low for a long stretch so that the result
    // register fills, the next series loads behind it and the input stalls.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen == HOLD_AT_RESULT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                results_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (results_seen >= 40 && results_seen < 56)
                results_ch.ready <= 1'b1;
            else
                results_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Check every result transaction at the rising edge that moves it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && results_ch.valid && results_ch.ready)
            begin
                ledger.check_result(results_ch.pair_count, results_ch.series_length,
                                    results_ch.overflowed);
                results_seen++;
            end
        end
    end

    // Watchdog: give up well beyond the slowest correct run, which is
    // dominated by the quadratic scan of the one full series.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int first_random;
        samples_ch.valid        <= 1'b0;
        samples_ch.sample_value <= '0;
        samples_ch.last_sample  <= 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Single-sample series at zero and at the top of the range.
        push_sample(32'sh0000_0000, 1'b1);
        push_sample(32'sh7FFF_FFFF, 1'b1);
        // Range extremes both ways round: the order must be signed.
        push_sample(32'sh8000_0000, 1'b0);
        push_sample(32'sh7FFF_FFFF, 1'b1);
        push_sample(32'sh7FFF_FFFF, 1'b0);
        push_sample(32'sh8000_0000, 1'b1);
        // Equal samples never form a pair.
        push_sample(32'sh0000_0005, 1'b0);
        push_sample(32'sh0000_0005, 1'b1);
        // Minus one below one, across the sign boundary.
        push_sample(32'shFFFF_FFFF, 1'b0);
        push_sample(32'sh0000_0001, 1'b1);
        // A dip in the middle blocks some pairs.
        push_sample(32'sh0000_0001, 1'b0);
        push_sample(32'sh0000_0003, 1'b0);
        push_sample(32'sh0000_0002, 1'b0);
        push_sample(32'sh0000_0004, 1'b1);
        // Strictly rising through zero: every pair counts.
        push_sample(-32'sd2, 1'b0);
        push_sample(-32'sd1, 1'b0);
        push_sample(32'sh0000_0000, 1'b0);
        push_sample(32'sh0000_0001, 1'b1);
        // Q16.16 values 1.0, -1.0 and 0.5.
        push_sample(32'sh0001_0000, 1'b0);
        push_sample(32'shFFFF_0000, 1'b0);
        push_sample(32'sh0000_8000, 1'b1);

        first_random = sent_count;
        while (sent_count - first_random < RANDOM_ITEMS)
            send_random_series();

        // Overrun the store with a strictly rising series, so that the count
        // peaks, then drop a few more samples, the marked one among them.
        for (int k = 0; k < DEPTH + OVERRUN_EXTRA; k++)
        begin
            if (k < DEPTH)
                push_sample(k * 3 - 1500, 1'b0);
            else
                push_sample($urandom(), k == DEPTH + OVERRUN_EXTRA - 1);
        end

        @(negedge clk);
        samples_ch.valid <= 1'b0;

        // Drain, then watch a little longer for stray results.
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (ledger.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
